// ----- src/ltfc_pkg.sv -----
package ltfc_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 16;

    localparam int ERR_W    = 16;
    localparam int PAT_W    = 8;
    localparam int OP_W     = 2;
    localparam int CNT_OUT_W = 16;
    localparam int DEB_W    = 16;
    localparam int LAP_W    = 8;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_CNT  = 7;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = NUM_CNT * CNT_OUT_W;

    localparam logic [PAT_W-1:0] PAT_ALL_ON = 8'hFF;
    localparam logic [PAT_W-1:0] PAT_ALL_OFF = 8'h00;

    localparam logic signed [ERR_W-1:0] LOW_BOUND_RST  = -16'sd100;
    localparam logic signed [ERR_W-1:0] HIGH_BOUND_RST = 16'sd100;
    localparam logic [DEB_W-1:0]        DEBOUNCE_RST   = 16'd50;
    localparam logic [LAP_W-1:0]        LAP_TARGET_RST = 8'd1;

    typedef enum logic [OP_W-1:0] {
        OP_CLASSIFY = 2'd0,
        OP_STOP_CHK = 2'd1,
        OP_CLEAR    = 2'd2,
        OP_UNUSED   = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ERR_LOW   = 2'd0,
        REG_ERR_HIGH  = 2'd1,
        REG_DEBOUNCE  = 2'd2,
        REG_LAP       = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic                 stop_now;
        logic [CNT_OUT_W-1:0] pitch_count;
        logic [CNT_OUT_W-1:0] lost_count;
        logic [CNT_OUT_W-1:0] marker_count;
        logic [CNT_OUT_W-1:0] curve_count;
        logic [CNT_OUT_W-1:0] crossing_count;
        logic [CNT_OUT_W-1:0] straight_count;
        logic [CNT_OUT_W-1:0] line_count;
    } result_t;

endpackage

// ----- src/line_track_feature_counter_core.sv -----
// Channel   Dir  Fields (tdata / tuser, lowest bit first)
// s_axis    in   tdata: track_error[15:0] center_pattern[23:16] center_bit[24]
//                middle_bit[25] left_bit[26] right_bit[27]; tuser: operation[1:0]
// m_axis    out  tdata: line, straight, crossing, curve, marker, lost, pitch
//                counts, 16 bits each; tuser: stop_now
// cfg       in   cfg_we, cfg_index, cfg_wdata
//
// One item per cycle sustained while the skid entry is free; each result is registered
// into the result register, or the skid entry while it is held. Counters and countdown
// update at the accept edge. A two-entry output stage (result register plus skid)
// parts the sides, so s_tready drops only when both entries hold results.
// Reset clears counters and countdown and loads the register defaults.
module line_track_feature_counter_core #(
    parameter int COUNT_WIDTH = ltfc_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ltfc_pkg::S_TDATA_W-1:0]   s_tdata,   // error, pattern, c, m, l, r
    input  logic [ltfc_pkg::OP_W-1:0]        s_tuser,   // operation
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ltfc_pkg::M_TDATA_W-1:0]   m_tdata,   // line..pitch counts
    output logic                             m_tuser,   // stop_now
    input  logic                             cfg_we,
    input  logic [ltfc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ltfc_pkg::CFG_W-1:0]       cfg_wdata
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
    localparam int CMP_W = COUNT_WIDTH + ltfc_pkg::LAP_W;

    // configuration
    logic signed [ltfc_pkg::ERR_W-1:0] err_low_reg, err_high_reg;
    logic [ltfc_pkg::DEB_W-1:0]        debounce_ticks_reg;
    logic [ltfc_pkg::LAP_W-1:0]        lap_target_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_low_reg        <= ltfc_pkg::LOW_BOUND_RST;
            err_high_reg       <= ltfc_pkg::HIGH_BOUND_RST;
            debounce_ticks_reg <= ltfc_pkg::DEBOUNCE_RST;
            lap_target_reg     <= ltfc_pkg::LAP_TARGET_RST;
        end
        else if (cfg_we)
        begin
            unique case (ltfc_pkg::cfg_idx_t'(cfg_index))
                ltfc_pkg::REG_ERR_LOW:  err_low_reg        <= $signed(cfg_wdata);
                ltfc_pkg::REG_ERR_HIGH: err_high_reg       <= $signed(cfg_wdata);
                ltfc_pkg::REG_DEBOUNCE: debounce_ticks_reg <= cfg_wdata;
                ltfc_pkg::REG_LAP:      lap_target_reg     <= cfg_wdata[ltfc_pkg::LAP_W-1:0];
                default: ;
            endcase
        end
    end

    // input unpack
    logic signed [ltfc_pkg::ERR_W-1:0] err;
    logic [ltfc_pkg::PAT_W-1:0]        pat;
    logic                              c_bit, m_bit, l_bit, r_bit;
    ltfc_pkg::op_t                     op;

    assign err   = $signed(s_tdata[15:0]);
    assign pat   = s_tdata[23:16];
    assign c_bit = s_tdata[24];
    assign m_bit = s_tdata[25];
    assign l_bit = s_tdata[26];
    assign r_bit = s_tdata[27];
    assign op    = ltfc_pkg::op_t'(s_tuser);

    // state
    logic [COUNT_WIDTH-1:0] line_reg, straight_reg, crossing_reg, curve_reg;
    logic [COUNT_WIDTH-1:0] marker_reg, lost_reg, pitch_reg;
    logic [COUNT_WIDTH-1:0] line_next, straight_next, crossing_next, curve_next;
    logic [COUNT_WIDTH-1:0] marker_next, lost_next, pitch_next;
    logic [ltfc_pkg::DEB_W-1:0] debounce_reg, debounce_next;
    logic                       stop_calc;

    logic accept_in, take_out;
    assign accept_in = s_tvalid && s_tready;
    assign take_out  = m_tvalid && m_tready;

    function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] v);
        bump = (v == CNT_MAX) ? v : v + COUNT_WIDTH'(1);
    endfunction

    logic in_window, crossing, marker, dark, outside;
    logic [COUNT_WIDTH-1:0] marker_bumped;

    always_comb
    begin
        in_window     = (err > err_low_reg) && (err < err_high_reg);
        outside       = (err <= err_low_reg) || (err >= err_high_reg);
        crossing      = (pat == ltfc_pkg::PAT_ALL_ON) && c_bit && l_bit && r_bit;
        marker        = r_bit && !crossing;
        dark          = (pat == ltfc_pkg::PAT_ALL_OFF) && !c_bit;
        marker_bumped = bump(marker_reg);

        line_next     = line_reg;
        straight_next = straight_reg;
        crossing_next = crossing_reg;
        curve_next    = curve_reg;
        marker_next   = marker_reg;
        lost_next     = lost_reg;
        pitch_next    = pitch_reg;
        debounce_next = debounce_reg;
        stop_calc     = 1'b0;

        case (op)
            ltfc_pkg::OP_CLASSIFY:
            begin
                if (in_window)               line_next     = bump(line_reg);
                if (err == '0 && c_bit && m_bit) straight_next = bump(straight_reg);
                if (crossing)                crossing_next = bump(crossing_reg);
                if (l_bit && !crossing)      curve_next    = bump(curve_reg);
                if (marker)                  marker_next   = marker_bumped;
                if (dark && outside)         lost_next     = bump(lost_reg);
                if (dark && in_window)       pitch_next    = bump(pitch_reg);
            end
            ltfc_pkg::OP_STOP_CHK:
            begin
                if (debounce_reg != '0)
                begin
                    debounce_next = debounce_reg - ltfc_pkg::DEB_W'(1);
                end
                else if (marker)
                begin
                    marker_next   = marker_bumped;
                    debounce_next = debounce_ticks_reg;
                    // half the marker count: two markers per lap
                    stop_calc     = CMP_W'(marker_bumped >> 1) >= CMP_W'(lap_target_reg);
                end
            end
            ltfc_pkg::OP_CLEAR:
            begin
                line_next     = '0;
                straight_next = '0;
                crossing_next = '0;
                curve_next    = '0;
                marker_next   = '0;
                lost_next     = '0;
                pitch_next    = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg     <= '0;
            straight_reg <= '0;
            crossing_reg <= '0;
            curve_reg    <= '0;
            marker_reg   <= '0;
            lost_reg     <= '0;
            pitch_reg    <= '0;
            debounce_reg <= '0;
        end
        else if (accept_in)
        begin
            line_reg     <= line_next;
            straight_reg <= straight_next;
            crossing_reg <= crossing_next;
            curve_reg    <= curve_next;
            marker_reg   <= marker_next;
            lost_reg     <= lost_next;
            pitch_reg    <= pitch_next;
            debounce_reg <= debounce_next;
        end
    end

    ltfc_pkg::result_t new_res;
    always_comb
    begin
        new_res.stop_now       = stop_calc;
        new_res.line_count     = ltfc_pkg::CNT_OUT_W'(line_next);
        new_res.straight_count = ltfc_pkg::CNT_OUT_W'(straight_next);
        new_res.crossing_count = ltfc_pkg::CNT_OUT_W'(crossing_next);
        new_res.curve_count    = ltfc_pkg::CNT_OUT_W'(curve_next);
        new_res.marker_count   = ltfc_pkg::CNT_OUT_W'(marker_next);
        new_res.lost_count     = ltfc_pkg::CNT_OUT_W'(lost_next);
        new_res.pitch_count    = ltfc_pkg::CNT_OUT_W'(pitch_next);
    end

    // output register plus skid entry
    ltfc_pkg::result_t out_reg, skid_reg;
    logic out_valid_reg, out_valid_next, skid_valid_reg, skid_valid_next;
    logic load_out_new, load_out_skid, load_skid;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out_new    = 1'b0;
        load_out_skid   = 1'b0;
        load_skid       = 1'b0;
        if (take_out || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                load_out_skid   = 1'b1;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (accept_in)
            begin
                load_out_new   = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (accept_in)
        begin
            load_skid       = 1'b1;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out_skid)
            out_reg <= skid_reg;
        else if (load_out_new)
            out_reg <= new_res;
        if (load_skid)
            skid_reg <= new_res;
    end

    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.stop_now;
    assign m_tdata  = {out_reg.pitch_count, out_reg.lost_count, out_reg.marker_count,
                       out_reg.curve_count, out_reg.crossing_count,
                       out_reg.straight_count, out_reg.line_count};

    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept_in && op == ltfc_pkg::OP_CLEAR) |=>
            (line_reg == '0 && marker_reg == '0 && pitch_reg == '0))
        else $error("counters not cleared");

    a_debounce_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (accept_in && op == ltfc_pkg::OP_STOP_CHK && debounce_reg != '0) |=>
            (debounce_reg == $past(debounce_reg) - ltfc_pkg::DEB_W'(1)
             && marker_reg == $past(marker_reg)))
        else $error("debounce countdown misbehaved");

    a_stop_only_check: assert property (@(posedge clk) disable iff (!rst_n)
        (accept_in && op != ltfc_pkg::OP_STOP_CHK && !skid_valid_reg
         && (take_out || !out_valid_reg)) |=> !m_tuser)
        else $error("stop reported for non stop-check item");

endmodule

// ----- sim/line_track_feature_counter_core_tb.sv -----
module line_track_feature_counter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW             = ltfc_pkg::COUNT_WIDTH_DEFAULT;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_ITEMS   = 1500;
    localparam int QUIET_TAIL     = 300;
    localparam int SETTING_SPAN   = 400;
    localparam int MAX_REPORTS    = 40;
    localparam int TALLY_ROUNDS   = 40;

    // tally slots, same order as the output count fields
    localparam int T_LINE     = 0;
    localparam int T_STRAIGHT = 1;
    localparam int T_CROSSING = 2;
    localparam int T_CURVE    = 3;
    localparam int T_MARKER   = 4;
    localparam int T_LOST     = 5;
    localparam int T_PITCH    = 6;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    logic [ltfc_pkg::S_TDATA_W-1:0]    s_tdata   = '0;  // error, pattern, c, m, l, r, zero pad
    logic [ltfc_pkg::OP_W-1:0]         s_tuser   = '0;  // operation
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    logic [ltfc_pkg::M_TDATA_W-1:0]    m_tdata;  // line, straight, crossing, curve, marker,
                                                 // lost, pitch
    logic                              m_tuser;  // stop_now
    logic                              cfg_we    = 1'b0;
    logic [ltfc_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [ltfc_pkg::CFG_W-1:0]        cfg_wdata = '0;

    // predicted block state
    logic signed [ltfc_pkg::ERR_W-1:0] win_low         = ltfc_pkg::LOW_BOUND_RST;
    logic signed [ltfc_pkg::ERR_W-1:0] win_high        = ltfc_pkg::HIGH_BOUND_RST;
    logic [ltfc_pkg::DEB_W-1:0]        debounce_reload = ltfc_pkg::DEBOUNCE_RST;
    logic [ltfc_pkg::DEB_W-1:0]        debounce_left   = '0;
    logic [ltfc_pkg::LAP_W-1:0]        lap_goal        = ltfc_pkg::LAP_TARGET_RST;
    logic [CW-1:0]                     tally [ltfc_pkg::NUM_CNT];

    ltfc_pkg::result_t pending_counts [$];

    int mismatches   = 0;
    int stall_cycles = 0;
    bit tx_idle      = 1'b0;
    bit rx_idle      = 1'b0;
    bit hold_req     = 1'b0;

    line_track_feature_counter_core #(
        .COUNT_WIDTH (CW)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] t);
        return (&t) ? t : t + 1'b1;
    endfunction

    task automatic advance_tallies(input ltfc_pkg::op_t op,
                                   input logic signed [ltfc_pkg::ERR_W-1:0] err,
                                   input logic [ltfc_pkg::PAT_W-1:0] pat,
                                   input logic c_on, m_on, l_on, r_on);
        logic              in_window;
        logic              crossing;
        logic              marker;
        logic              dark;
        logic              stop;
        ltfc_pkg::result_t exp_res;
        in_window = (err > win_low) && (err < win_high);
        crossing  = (pat == ltfc_pkg::PAT_ALL_ON) && c_on && l_on && r_on;
        marker    = r_on && !crossing;
        dark      = (pat == ltfc_pkg::PAT_ALL_OFF) && !c_on;
        stop      = 1'b0;
        case (op)
            ltfc_pkg::OP_CLASSIFY:
            begin
                if (in_window)
                    tally[T_LINE] = sat_inc(tally[T_LINE]);
                if (err == 0 && c_on && m_on)
                    tally[T_STRAIGHT] = sat_inc(tally[T_STRAIGHT]);
                if (crossing)
                    tally[T_CROSSING] = sat_inc(tally[T_CROSSING]);
                if (l_on && !crossing)
                    tally[T_CURVE] = sat_inc(tally[T_CURVE]);
                if (marker)
                    tally[T_MARKER] = sat_inc(tally[T_MARKER]);
                if (dark && !in_window)
                    tally[T_LOST] = sat_inc(tally[T_LOST]);
                if (dark && in_window)
                    tally[T_PITCH] = sat_inc(tally[T_PITCH]);
            end
            ltfc_pkg::OP_STOP_CHK:
            begin
                if (debounce_left != 0)
                    debounce_left = debounce_left - 1'b1;
                else if (marker)
                begin
                    tally[T_MARKER] = sat_inc(tally[T_MARKER]);
                    debounce_left   = debounce_reload;
                    stop            = (tally[T_MARKER] >> 1) >= lap_goal;
                end
            end
            ltfc_pkg::OP_CLEAR:
            begin
                foreach (tally[i])
                    tally[i] = '0;
            end
            default:
            begin
            end
        endcase
        exp_res.stop_now       = stop;
        exp_res.line_count     = tally[T_LINE][ltfc_pkg::CNT_OUT_W-1:0];
        exp_res.straight_count = tally[T_STRAIGHT][ltfc_pkg::CNT_OUT_W-1:0];
        exp_res.crossing_count = tally[T_CROSSING][ltfc_pkg::CNT_OUT_W-1:0];
        exp_res.curve_count    = tally[T_CURVE][ltfc_pkg::CNT_OUT_W-1:0];
        exp_res.marker_count   = tally[T_MARKER][ltfc_pkg::CNT_OUT_W-1:0];
        exp_res.lost_count     = tally[T_LOST][ltfc_pkg::CNT_OUT_W-1:0];
        exp_res.pitch_count    = tally[T_PITCH][ltfc_pkg::CNT_OUT_W-1:0];
        pending_counts.push_back(exp_res);
    endtask

    // called right after a falling edge, returns right after one
    task automatic send_item(input ltfc_pkg::op_t op,
                             input logic signed [ltfc_pkg::ERR_W-1:0] err,
                             input logic [ltfc_pkg::PAT_W-1:0] pat,
                             input logic c_on, m_on, l_on, r_on);
        if (tx_idle && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, r_on, l_on, m_on, c_on, pat, err};
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        advance_tallies(op, err, pat, c_on, m_on, l_on, r_on);
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_counts.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    // block must be idle when this is called
    task automatic write_reg(input ltfc_pkg::cfg_idx_t idx,
                             input logic [ltfc_pkg::CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            ltfc_pkg::REG_ERR_LOW:  win_low         = val;
            ltfc_pkg::REG_ERR_HIGH: win_high        = val;
            ltfc_pkg::REG_DEBOUNCE: debounce_reload = val;
            ltfc_pkg::REG_LAP:      lap_goal        = val[ltfc_pkg::LAP_W-1:0];
            default:
            begin
            end
        endcase
        @(negedge clk);
    endtask

    function automatic ltfc_pkg::op_t pick_op();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return ltfc_pkg::OP_CLASSIFY;
        else if (roll < 88)
            return ltfc_pkg::OP_STOP_CHK;
        else if (roll < 93)
            return ltfc_pkg::OP_CLEAR;
        return ltfc_pkg::OP_UNUSED;
    endfunction

    // errors cluster at zero and around the window edges
    task automatic send_random(input ltfc_pkg::op_t op);
        logic signed [ltfc_pkg::ERR_W-1:0] err;
        logic [ltfc_pkg::PAT_W-1:0]        pat;
        logic                              r_on;
        int                                roll;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            err = '0;
        else if (roll < 45)
        begin
            err = $urandom_range(0, 1) ? win_low : win_high;
            err = err + ltfc_pkg::ERR_W'($urandom_range(0, 2)) - ltfc_pkg::ERR_W'(1);
        end
        else
            err = ltfc_pkg::ERR_W'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 30)
            pat = ltfc_pkg::PAT_ALL_OFF;
        else if (roll < 60)
            pat = ltfc_pkg::PAT_ALL_ON;
        else
            pat = ltfc_pkg::PAT_W'($urandom);
        r_on = (op == ltfc_pkg::OP_STOP_CHK) ? ($urandom_range(0, 9) != 0)
                                             : 1'($urandom_range(0, 1));
        send_item(op, err, pat, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), r_on);
    endtask

    task automatic load_random_settings();
        logic [ltfc_pkg::CFG_W-1:0] lo;
        logic [ltfc_pkg::CFG_W-1:0] hi;
        logic [ltfc_pkg::CFG_W-1:0] deb;
        lo  = ($urandom_range(0, 4) == 0) ? ltfc_pkg::CFG_W'($urandom)
                                          : ltfc_pkg::CFG_W'($urandom_range(0, 600) - 300);
        hi  = ($urandom_range(0, 4) == 0) ? ltfc_pkg::CFG_W'($urandom)
                                          : ltfc_pkg::CFG_W'($urandom_range(0, 600) - 300);
        deb = ($urandom_range(0, 9) != 0) ? ltfc_pkg::CFG_W'($urandom_range(0, 6))
                                          : ltfc_pkg::CFG_W'($urandom);
        write_reg(ltfc_pkg::REG_ERR_LOW, lo);
        write_reg(ltfc_pkg::REG_ERR_HIGH, hi);
        write_reg(ltfc_pkg::REG_DEBOUNCE, deb);
        // upper byte of the lap write must be ignored
        write_reg(ltfc_pkg::REG_LAP, {8'($urandom), 8'($urandom_range(0, 4))});
    endtask

    task automatic test_reset_behavior();
        // window edges are exclusive
        send_item(ltfc_pkg::OP_CLASSIFY, -16'sd100, ltfc_pkg::PAT_ALL_OFF,
                  1'b0, 1'b0, 1'b0, 1'b0);
        send_item(ltfc_pkg::OP_CLASSIFY, -16'sd99,  ltfc_pkg::PAT_ALL_OFF,
                  1'b0, 1'b0, 1'b0, 1'b0);
        send_item(ltfc_pkg::OP_CLASSIFY, 16'sd99,   ltfc_pkg::PAT_ALL_OFF,
                  1'b0, 1'b1, 1'b0, 1'b0);
        send_item(ltfc_pkg::OP_CLASSIFY, 16'sd100,  ltfc_pkg::PAT_ALL_OFF,
                  1'b0, 1'b0, 1'b0, 1'b0);
        send_item(ltfc_pkg::OP_CLASSIFY, 16'sd0,    8'h3C, 1'b1, 1'b1, 1'b0, 1'b0);
        // crossing masks curve and marker
        send_item(ltfc_pkg::OP_CLASSIFY, 16'sd0,    ltfc_pkg::PAT_ALL_ON,
                  1'b1, 1'b1, 1'b1, 1'b1);
        send_item(ltfc_pkg::OP_CLASSIFY, 16'sd500,  8'h81, 1'b0, 1'b0, 1'b1, 1'b0);
        send_item(ltfc_pkg::OP_CLASSIFY, -16'sd20,  8'h18, 1'b0, 1'b0, 1'b0, 1'b1);
        send_item(ltfc_pkg::OP_CLASSIFY, -16'sd32768, ltfc_pkg::PAT_ALL_OFF,
                  1'b0, 1'b1, 1'b0, 1'b0);
        send_item(ltfc_pkg::OP_CLASSIFY, 16'sd32767,  ltfc_pkg::PAT_ALL_ON,
                  1'b1, 1'b0, 1'b1, 1'b0);
        send_item(ltfc_pkg::OP_CLASSIFY, 16'sd7,    ltfc_pkg::PAT_ALL_OFF,
                  1'b1, 1'b1, 1'b0, 1'b0);
        send_item(ltfc_pkg::OP_UNUSED,   16'sd0,    ltfc_pkg::PAT_ALL_ON,
                  1'b1, 1'b1, 1'b1, 1'b1);
        send_item(ltfc_pkg::OP_STOP_CHK, 16'sd0,    8'h10, 1'b0, 1'b0, 1'b0, 1'b1);
        send_item(ltfc_pkg::OP_STOP_CHK, 16'sd0,    8'h10, 1'b0, 1'b0, 1'b0, 1'b1);
        send_item(ltfc_pkg::OP_STOP_CHK, -16'sd1,   ltfc_pkg::PAT_ALL_ON,
                  1'b1, 1'b1, 1'b1, 1'b1);
        send_item(ltfc_pkg::OP_CLEAR,    16'sd3,    8'h55, 1'b1, 1'b0, 1'b1, 1'b0);
        send_item(ltfc_pkg::OP_CLASSIFY, 16'sd1,    8'hAA, 1'b0, 1'b1, 1'b0, 1'b1);
    endtask

    task automatic test_register_extremes();
        // inverted window: no sample is in the window, so dark samples count as lost, never pitch
        wait_for_results();
        write_reg(ltfc_pkg::REG_ERR_LOW,  16'h7FFF);
        write_reg(ltfc_pkg::REG_ERR_HIGH, 16'h8000);
        write_reg(ltfc_pkg::REG_DEBOUNCE, 16'h0000);
        write_reg(ltfc_pkg::REG_LAP,      16'h0000);
        send_item(ltfc_pkg::OP_CLASSIFY, 16'sd0,     ltfc_pkg::PAT_ALL_OFF,
                  1'b0, 1'b0, 1'b0, 1'b0);
        send_item(ltfc_pkg::OP_CLASSIFY, 16'sd32767, ltfc_pkg::PAT_ALL_OFF,
                  1'b0, 1'b0, 1'b0, 1'b0);
        send_item(ltfc_pkg::OP_STOP_CHK, 16'sd0,     8'h01, 1'b0, 1'b0, 1'b0, 1'b1);
        send_item(ltfc_pkg::OP_STOP_CHK, 16'sd0,     8'h01, 1'b0, 1'b0, 1'b0, 1'b1);
        repeat (30) send_random(pick_op());

        wait_for_results();
        write_reg(ltfc_pkg::REG_ERR_LOW,  16'h8000);
        write_reg(ltfc_pkg::REG_ERR_HIGH, 16'h7FFF);
        write_reg(ltfc_pkg::REG_DEBOUNCE, 16'hFFFF);
        write_reg(ltfc_pkg::REG_LAP,      16'hA5FF);
        send_item(ltfc_pkg::OP_CLASSIFY, -16'sd32768, ltfc_pkg::PAT_ALL_OFF,
                  1'b0, 1'b0, 1'b0, 1'b0);
        send_item(ltfc_pkg::OP_CLASSIFY, 16'sd32767,  ltfc_pkg::PAT_ALL_OFF,
                  1'b0, 1'b0, 1'b0, 1'b0);
        send_item(ltfc_pkg::OP_CLASSIFY, -16'sd32767, ltfc_pkg::PAT_ALL_OFF,
                  1'b0, 1'b0, 1'b0, 1'b0);
        send_item(ltfc_pkg::OP_STOP_CHK, 16'sd0,      8'h02, 1'b0, 1'b0, 1'b0, 1'b1);
        send_item(ltfc_pkg::OP_STOP_CHK, 16'sd0,      8'h02, 1'b0, 1'b0, 1'b0, 1'b1);
        repeat (30) send_random(pick_op());

        wait_for_results();
        write_reg(ltfc_pkg::REG_ERR_LOW,  -16'sd5);
        write_reg(ltfc_pkg::REG_ERR_HIGH, 16'sd5);
        write_reg(ltfc_pkg::REG_DEBOUNCE, 16'd3);
        write_reg(ltfc_pkg::REG_LAP,      16'd2);
        repeat (60) send_random(pick_op());
    endtask

    task automatic test_stop_debounce();
        repeat (3)
        begin
            wait_for_results();
            write_reg(ltfc_pkg::REG_DEBOUNCE, ltfc_pkg::CFG_W'($urandom_range(0, 4)));
            write_reg(ltfc_pkg::REG_LAP,      ltfc_pkg::CFG_W'($urandom_range(1, 3)));
            send_random(ltfc_pkg::OP_CLEAR);
            repeat (60)
                send_random(($urandom_range(0, 99) < 65) ? ltfc_pkg::OP_STOP_CHK
                                                         : ltfc_pkg::OP_CLASSIFY);
        end
    endtask

    task automatic test_output_backpressure();
        wait_for_results();
        tx_idle  = 1'b0;
        hold_req = 1'b1;
        repeat (40) send_random(pick_op());
        // sender pauses until every result is back
        wait_for_results();
        tx_idle = 1'b1;
    endtask

    task automatic test_tally_burst();
        wait_for_results();
        write_reg(ltfc_pkg::REG_ERR_LOW,  -16'sd100);
        write_reg(ltfc_pkg::REG_ERR_HIGH, 16'sd100);
        write_reg(ltfc_pkg::REG_DEBOUNCE, 16'd0);
        write_reg(ltfc_pkg::REG_LAP,      16'd255);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_item(ltfc_pkg::OP_CLEAR, 16'sd0, ltfc_pkg::PAT_ALL_OFF, 1'b0, 1'b0, 1'b0, 1'b0);
        // four samples per round cover all seven tallies
        repeat (TALLY_ROUNDS)
        begin
            send_item(ltfc_pkg::OP_CLASSIFY, 16'sd0,     8'h0F,
                      1'b1, 1'b1, 1'b1, 1'b1);
            send_item(ltfc_pkg::OP_CLASSIFY, 16'sd0,     ltfc_pkg::PAT_ALL_ON,
                      1'b1, 1'b1, 1'b1, 1'b1);
            send_item(ltfc_pkg::OP_CLASSIFY, 16'sd0,     ltfc_pkg::PAT_ALL_OFF,
                      1'b0, 1'b0, 1'b0, 1'b0);
            send_item(ltfc_pkg::OP_CLASSIFY, 16'sd30000, ltfc_pkg::PAT_ALL_OFF,
                      1'b0, 1'b0, 1'b0, 1'b0);
        end
        repeat (3)
            send_item(ltfc_pkg::OP_STOP_CHK, 16'sd0, 8'h01, 1'b0, 1'b0, 1'b0, 1'b1);
        send_item(ltfc_pkg::OP_CLEAR, 16'sd0, ltfc_pkg::PAT_ALL_OFF, 1'b0, 1'b0, 1'b0, 1'b0);
        wait_for_results();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    task automatic test_random_mix();
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % SETTING_SPAN == 0)
            begin
                wait_for_results();
                load_random_settings();
            end
            if (i == RANDOM_ITEMS - QUIET_TAIL)
            begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end
            send_random(pick_op());
        end
    endtask

    // result sink with random stalls and one long hold-off on request
    initial
    begin
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (rx_idle && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(negedge clk);
        end
    end

    task automatic check_field(input string name,
                               input logic [ltfc_pkg::CNT_OUT_W-1:0] want,
                               input logic [ltfc_pkg::CNT_OUT_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        ltfc_pkg::result_t got;
        ltfc_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = ltfc_pkg::result_t'({m_tuser, m_tdata});
            if (pending_counts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $error("result with nothing expected: stop_now %0b", got.stop_now);
            end
            else
            begin
                want = pending_counts.pop_front();
                check_field("stop_now",       want.stop_now,       got.stop_now);
                check_field("line_count",     want.line_count,     got.line_count);
                check_field("straight_count", want.straight_count, got.straight_count);
                check_field("crossing_count", want.crossing_count, got.crossing_count);
                check_field("curve_count",    want.curve_count,    got.curve_count);
                check_field("marker_count",   want.marker_count,   got.marker_count);
                check_field("lost_count",     want.lost_count,     got.lost_count);
                check_field("pitch_count",    want.pitch_count,    got.pitch_count);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : watchdog
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("FAIL line_track_feature_counter_core");
        $finish;
    end

    initial
    begin
        foreach (tally[i])
            tally[i] = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        tx_idle = 1'b1;
        rx_idle = 1'b1;

        test_reset_behavior();
        test_register_extremes();
        test_stop_debounce();
        test_output_backpressure();
        test_tally_burst();
        test_random_mix();

        wait_for_results();
        repeat (4) @(negedge clk);
        if (mismatches == 0 && pending_counts.size() == 0)
            $display("PASS line_track_feature_counter_core");
        else
            $display("FAIL line_track_feature_counter_core");
        $finish;
    end

endmodule
